[hw/rtl/nta_pkg.sv]
package nta_pkg;

    typedef enum logic [1:0] {
        MODE_BIN_BYTE = 2'd0,
        MODE_HEX_BYTE = 2'd1,
        MODE_HEX_WORD = 2'd2,
        MODE_DEC_SIGNED = 2'd3
    } t_mode;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_ONE   = 7'h31;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_B     = 7'h62;
    localparam logic [6:0] CHAR_H     = 7'h68;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [3:0] DEC_TEN    = 4'd10;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [3:0] d;
        d = nib & NIBBLE_MASK;
        if (d < DEC_TEN) begin
            hex_char = CHAR_ZERO + {3'b000, d};
        end else begin
            hex_char = CHAR_UPPER_A + {3'b000, d - DEC_TEN};
        end
    endfunction

endpackage

[hw/rtl/number_to_ascii_formatter.sv]
// In the binary and hex formats the characters are emitted from the registered input word; in
// signed decimal they follow the 16-step bit-serial BCD conversion, and the first character
// comes later for short positive numbers whose leading zeros are suppressed.
// Busy stays high from start until the last character of the word is shown, in every
// format, and a start is taken only while busy is low.
// A new word may start in the cycle in which the last character is shown.
// Reset is synchronous and active low; it returns the block to idle and drops the strobe.
module number_to_ascii_formatter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  nta_pkg::t_mode  i_mode,
    input  logic [15:0]     i_number,
    output logic            o_valid,
    output logic [6:0]      o_character,
    output logic            o_last
);
    import nta_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state      r_state;
    t_mode       r_mode;
    logic [15:0] r_shift;
    logic [19:0] r_bcd;
    logic [3:0]  r_cnt;
    logic        r_neg;
    logic        r_started;

    logic [19:0] bcd_adj;
    logic [3:0]  dec_digit;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    assign dec_digit = r_bcd[19:16];
    assign busy      = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= 4'd0;
            r_neg     <= 1'b0;
            r_started <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode    <= i_mode;
                        r_started <= 1'b0;
                        r_neg     <= 1'b0;
                        unique case (i_mode)
                            MODE_BIN_BYTE: begin
                                r_shift <= {i_number[7:0], 8'h00};
                                r_cnt   <= 4'd8;
                                r_state <= S_EMIT;
                            end
                            MODE_HEX_BYTE: begin
                                r_shift <= {i_number[7:0], 8'h00};
                                r_cnt   <= 4'd2;
                                r_state <= S_EMIT;
                            end
                            MODE_HEX_WORD: begin
                                r_shift <= i_number;
                                r_cnt   <= 4'd4;
                                r_state <= S_EMIT;
                            end
                            MODE_DEC_SIGNED: begin
                                r_neg   <= i_number[15];
                                r_shift <= i_number[15] ? (16'h0000 - i_number) : i_number;
                                r_bcd   <= 20'h00000;
                                r_cnt   <= 4'd0;
                                r_state <= S_CONV;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CONV: begin
                    r_bcd   <= {bcd_adj[18:0], r_shift[15]};
                    r_shift <= {r_shift[14:0], 1'b0};
                    if (r_cnt == 4'd15) begin
                        r_cnt   <= 4'd5;
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_EMIT: begin
                    unique case (r_mode) inside
                        MODE_BIN_BYTE, MODE_HEX_BYTE, MODE_HEX_WORD: begin
                            o_valid <= 1'b1;
                            if (r_cnt == 4'd0) begin
                                o_character <= (r_mode == MODE_BIN_BYTE) ? CHAR_B : CHAR_H;
                                o_last      <= 1'b1;
                                r_state     <= S_IDLE;
                            end else begin
                                o_last <= 1'b0;
                                r_cnt  <= r_cnt - 4'd1;
                                if (r_mode == MODE_BIN_BYTE) begin
                                    o_character <= r_shift[15] ? CHAR_ONE : CHAR_ZERO;
                                    r_shift     <= {r_shift[14:0], 1'b0};
                                end else begin
                                    o_character <= hex_char(r_shift[15:12]);
                                    r_shift     <= {r_shift[11:0], 4'h0};
                                end
                            end
                        end
                        MODE_DEC_SIGNED: begin
                            if (r_neg) begin
                                o_valid     <= 1'b1;
                                o_character <= CHAR_MINUS;
                                o_last      <= 1'b0;
                                r_neg       <= 1'b0;
                            end else begin
                                r_bcd <= {r_bcd[15:0], 4'h0};
                                r_cnt <= r_cnt - 4'd1;
                                if (r_started || dec_digit != 4'd0 || r_cnt == 4'd1) begin
                                    o_valid     <= 1'b1;
                                    o_character <= CHAR_ZERO + {3'b000, dec_digit};
                                    o_last      <= (r_cnt == 4'd1);
                                    r_started   <= 1'b1;
                                end
                                if (r_cnt == 4'd1) begin
                                    r_state <= S_IDLE;
                                end
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[bench/number_to_ascii_formatter_tb.sv]
`timescale 1ns / 100ps

module number_to_ascii_formatter_tb;

    import nta_pkg::*;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_char;

    typedef struct {
        t_mode       mode;
        logic [15:0] number;
        bit          drain;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_mode       i_mode = MODE_BIN_BYTE;
    logic [15:0] i_number = 16'h0000;
    logic        o_valid;
    logic [6:0]  o_character;
    logic        o_last;

    t_word word_q[$];
    t_char expected_chars[$];
    int    mismatches = 0;
    int    gap_cnt = 0;

    number_to_ascii_formatter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [6:0] nibble_glyph(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHAR_ZERO + {3'b000, nib};
        end
        return CHAR_UPPER_A + {3'b000, nib} - 7'd10;
    endfunction

    task automatic predict_characters(input t_mode mode, input logic [15:0] number);
        logic [6:0]  text [0:8];
        logic [6:0]  digits [0:4];
        logic [15:0] mag;
        logic [15:0] rem;
        int          len;
        int          n;
        int          i;
        t_char       c;
        len = 0;
        case (mode)
            MODE_BIN_BYTE: begin
                for (i = 7; i >= 0; i--) begin
                    text[len] = number[i] ? CHAR_ONE : CHAR_ZERO;
                    len = len + 1;
                end
                text[len] = CHAR_B;
                len = len + 1;
            end
            MODE_HEX_BYTE: begin
                text[0] = nibble_glyph(number[7:4]);
                text[1] = nibble_glyph(number[3:0]);
                text[2] = CHAR_H;
                len = 3;
            end
            MODE_HEX_WORD: begin
                text[0] = nibble_glyph(number[15:12]);
                text[1] = nibble_glyph(number[11:8]);
                text[2] = nibble_glyph(number[7:4]);
                text[3] = nibble_glyph(number[3:0]);
                text[4] = CHAR_H;
                len = 5;
            end
            default: begin
                mag = number;
                if (number[15]) begin
                    text[len] = CHAR_MINUS;
                    len = len + 1;
                    mag = 16'd0 - number;
                end
                n = 0;
                do begin
                    rem = mag % 16'd10;
                    digits[n] = CHAR_ZERO + rem[6:0];
                    mag = mag / 16'd10;
                    n = n + 1;
                end while (mag != 16'd0);
                while (n > 0) begin
                    n = n - 1;
                    text[len] = digits[n];
                    len = len + 1;
                end
            end
        endcase
        for (i = 0; i < len; i++) begin
            c.character = text[i];
            c.last = (i == len - 1);
            expected_chars.push_back(c);
        end
    endtask

    task automatic add_word(input t_mode mode, input logic [15:0] number, input bit drain);
        t_word w;
        w.mode = mode;
        w.number = number;
        w.drain = drain;
        word_q.push_back(w);
    endtask

    always @(posedge i_clk) begin
        t_word nxt;
        bit    idle_ok;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_cnt = 0;
        end else begin
            if (start && !busy) begin
                predict_characters(i_mode, i_number);
            end
            if (!start || !busy) begin
                idle_ok = (word_q.size() > 60) && (((word_q.size() / 50) % 2) == 0);
                if (gap_cnt > 0) begin
                    gap_cnt = gap_cnt - 1;
                    start <= 1'b0;
                end else if (word_q.size() == 0) begin
                    start <= 1'b0;
                end else if (word_q[0].drain && expected_chars.size() != 0) begin
                    start <= 1'b0;
                end else if (idle_ok && $urandom_range(0, 3) == 0) begin
                    gap_cnt = $urandom_range(0, 4);
                    start <= 1'b0;
                end else begin
                    nxt = word_q.pop_front();
                    i_mode <= nxt.mode;
                    i_number <= nxt.number;
                    start <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_char exp_c;
        if (i_rst_n && o_valid) begin
            if (expected_chars.size() == 0) begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, o_character, o_last);
            end else begin
                exp_c = expected_chars.pop_front();
                if (o_character !== exp_c.character) begin
                    mismatches = mismatches + 1;
                    $display("%0t: character mismatch: expected %h, actual %h",
                             $time, exp_c.character, o_character);
                end
                if (o_last !== exp_c.last) begin
                    mismatches = mismatches + 1;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, exp_c.last, o_last);
                end
            end
        end
    end

    initial begin
        int          k;
        int          sel;
        t_mode       mode;
        logic [15:0] number;

        add_word(MODE_BIN_BYTE, 16'h0000, 1'b0);
        add_word(MODE_BIN_BYTE, 16'h00FF, 1'b0);
        add_word(MODE_BIN_BYTE, 16'hFF00, 1'b0);
        add_word(MODE_BIN_BYTE, 16'hA5A5, 1'b0);
        add_word(MODE_HEX_BYTE, 16'h0000, 1'b0);
        add_word(MODE_HEX_BYTE, 16'h00FF, 1'b0);
        add_word(MODE_HEX_BYTE, 16'hAB3C, 1'b0);
        add_word(MODE_HEX_WORD, 16'h0000, 1'b0);
        add_word(MODE_HEX_WORD, 16'hFFFF, 1'b0);
        add_word(MODE_HEX_WORD, 16'h1234, 1'b0);
        add_word(MODE_HEX_WORD, 16'hABCD, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'd0, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'd1, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'd9, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'd10, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'd12345, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'h7FFF, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'h8000, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'h8001, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'hFFFF, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'hFFF6, 1'b0);
        add_word(MODE_DEC_SIGNED, 16'hCFC7, 1'b0);

        for (k = 0; k < 480; k++) begin
            mode = t_mode'($urandom_range(0, 3));
            sel = $urandom_range(0, 7);
            case (sel)
                4: number = 16'($urandom_range(0, 20));
                5: number = 16'd0 - 16'($urandom_range(1, 20));
                6: number = 16'h7FF0 + 16'($urandom_range(0, 32));
                7: number = $urandom_range(0, 1) ? 16'($urandom_range(9990, 10010))
                                                 : 16'd0 - 16'($urandom_range(9990, 10010));
                default: number = 16'($urandom);
            endcase
            add_word(mode, number, (k == 0) || (k == 240));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0 || start) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("number_to_ascii_formatter_tb passed");
        end else begin
            $display("number_to_ascii_formatter_tb failed");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("number_to_ascii_formatter_tb failed");
        $finish;
    end

endmodule
